// ===== rtl/text_glyph_renderer_core_macros.svh =====
// Assertion macros for the text glyph renderer core.
// Used by the top level only; expects clk and rst in scope.
`ifndef TEXT_GLYPH_RENDERER_CORE_MACROS_SVH
`define TEXT_GLYPH_RENDERER_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define TGR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define TGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tgr_pkg.sv =====
// Package for the text glyph renderer: sequencer states, register map,
// command and character codes, read tags and small helpers. No dependencies.
`default_nettype none

package tgr_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_FILL,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Register index (byte address / 4)
  localparam logic [2:0] REG_FONT_BPC   = 3'd0;
  localparam logic [2:0] REG_GLYPH_W    = 3'd1;
  localparam logic [2:0] REG_GLYPH_H    = 3'd2;
  localparam logic [2:0] REG_BYTES_COL  = 3'd3;
  localparam logic [2:0] REG_COLOURS    = 3'd4;
  localparam logic [2:0] REG_START_X    = 3'd5;
  localparam logic [2:0] REG_START_Y    = 3'd6;
  localparam logic [2:0] REG_SWAP_AXES  = 3'd7;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_PUT  = 1'b1;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_FIRST   = 8'd32;
  localparam logic [7:0] CHAR_LAST    = 8'd127;

  localparam logic [2:0] HDR_BYTES = 3'd4;
  localparam logic [1:0] CELL_GAP  = 2'd2;

  // Tag that travels with a glyph memory read
  typedef struct packed {
    logic       is_width;
    logic [3:0] col;
    logic       half;
  } rd_tag_t;

  function automatic logic [15:0] swap16(input logic [15:0] c);
    return {c[7:0], c[15:8]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tgr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; contents are undefined until written.
`default_nettype none

module tgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/text_glyph_renderer_core.sv =====
// Text glyph renderer core: APB registers, glyph memory sequencer, pixel emit.
// Depends on tgr_pkg, tgr_ram and text_glyph_renderer_core_macros.svh.
//
// Bitmap-font character generator. A word on the input stream with tuser=0
// stores one font byte into the glyph memory. A word with tuser=1 puts a
// character: code 10 is a newline, codes 32..127 render a glyph, all other
// codes are dropped. A glyph first wraps the cursor if the cell would cross
// the panel edge, then its column bitmap is read out of the glyph memory
// through its single read port, one byte per cycle (the width byte plus one
// byte per column, two when the cell is taller than 8 rows), into a
// row-major pixel buffer. The buffer then drains four pixels per output
// word, one word per cycle while the output side takes them. Each word
// carries the glyph window and up to four byte-swapped RGB565 pixels;
// tlast marks the final word. One item is in work at a time; the output
// register lets the next item in while the last word still waits.
// FONT_BYTES must be a power of two.
// Configure only while no glyph is in flight.
`default_nettype none

`include "text_glyph_renderer_core_macros.svh"

module text_glyph_renderer_core
  import tgr_pkg::*;
#(
  parameter int PANEL_WIDTH    = 240,
  parameter int PANEL_HEIGHT   = 320,
  parameter int FONT_BYTES     = 4096,
  parameter int MAX_GLYPH_SIDE = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [11:0] font_addr, [19:12] font_byte, [27:20] char_code, [31:28] zero
  input  wire logic [31:0]  s_tdata,
  // [0] func
  input  wire logic [0:0]   s_tuser,
  // Output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [15:0] pixel_a, [31:16] pixel_b, [47:32] pixel_c, [63:48] pixel_d,
  // [66:64] pixel_count, [75:67] win_x0, [84:76] win_y0, [93:85] win_x1,
  // [102:94] win_y1, [103] zero
  output logic [103:0]      m_tdata,
  output logic              m_tlast,
  // APB configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  localparam int AW   = $clog2(FONT_BYTES);
  localparam int PIXB = MAX_GLYPH_SIDE * MAX_GLYPH_SIDE;
  localparam int PIXW = $clog2(PIXB);
  localparam int REMW = $clog2(PIXB + 1);
  localparam logic [4:0] SIDE_MAX = 5'(MAX_GLYPH_SIDE);
  localparam logic [9:0] PW_N     = 10'(PANEL_WIDTH);
  localparam logic [9:0] PH_N     = 10'(PANEL_HEIGHT);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [5:0]  font_bpc;
  logic [4:0]  glyph_w;
  logic [4:0]  glyph_h;
  logic [1:0]  bytes_col;
  logic [31:0] colours;
  logic [8:0]  start_x;
  logic [8:0]  start_y;
  logic        swap_axes;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      font_bpc  <= 6'd33;
      glyph_w   <= 5'd16;
      glyph_h   <= 5'd16;
      bytes_col <= 2'd2;
      colours   <= '0;
      start_x   <= '0;
      start_y   <= '0;
      swap_axes <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FONT_BPC:  font_bpc  <= pwdata[5:0];
        REG_GLYPH_W:   glyph_w   <= pwdata[4:0];
        REG_GLYPH_H:   glyph_h   <= pwdata[4:0];
        REG_BYTES_COL: bytes_col <= pwdata[1:0];
        REG_COLOURS:   colours   <= pwdata;
        REG_START_X:   start_x   <= pwdata[8:0];
        REG_START_Y:   start_y   <= pwdata[8:0];
        REG_SWAP_AXES: swap_axes <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FONT_BPC:  prdata = 32'(font_bpc);
      REG_GLYPH_W:   prdata = 32'(glyph_w);
      REG_GLYPH_H:   prdata = 32'(glyph_h);
      REG_BYTES_COL: prdata = 32'(bytes_col);
      REG_COLOURS:   prdata = colours;
      REG_START_X:   prdata = 32'(start_x);
      REG_START_Y:   prdata = 32'(start_y);
      REG_SWAP_AXES: prdata = 32'(swap_axes);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input word decode and derived geometry
  // ---------------------------------------------------------------------
  logic        in_func;
  logic [11:0] in_addr;
  logic [7:0]  in_byte;
  logic [7:0]  in_code;
  logic [15:0] in_addr_ext;
  logic        accept;
  logic        is_print;

  assign in_func     = s_tuser[0];
  assign in_addr     = s_tdata[11:0];
  assign in_byte     = s_tdata[19:12];
  assign in_code     = s_tdata[27:20];
  assign in_addr_ext = 16'(in_addr);
  assign accept      = s_tvalid & s_tready;
  assign is_print    = (in_code >= CHAR_FIRST) && (in_code <= CHAR_LAST);

  logic [4:0] hor;
  logic [4:0] vert;
  logic [9:0] pw;
  logic [9:0] ph;

  // Clamp the cell to the pixel buffer size
  assign hor  = (glyph_w > SIDE_MAX) ? SIDE_MAX : glyph_w;
  assign vert = (glyph_h > SIDE_MAX) ? SIDE_MAX : glyph_h;
  assign pw   = swap_axes ? PH_N : PW_N;
  assign ph   = swap_axes ? PW_N : PH_N;

  // ---------------------------------------------------------------------
  // Sequencer state and working registers
  // ---------------------------------------------------------------------
  state_t            state;
  state_t            state_next;
  logic [8:0]        cursor_x;
  logic [8:0]        cursor_y;
  logic [6:0]        code_ofs;
  logic [AW-1:0]     rec;
  logic [AW-1:0]     col_addr;
  logic [4:0]        ncols;
  logic              two_bytes;
  logic              iss_width;
  logic [3:0]        iss_col;
  logic              iss_half;
  logic              rd_valid;
  rd_tag_t           rd_tag;
  logic [7:0]        own_w;
  logic [PIXB-1:0]   pix;
  logic [REMW-1:0]   rem;

  // Glyph memory
  logic              ram_we;
  logic [AW-1:0]     ram_raddr;
  logic [7:0]        ram_rdata;

  tgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_glyph_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_addr_ext[AW-1:0]),
    .wdata (in_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Newline step shared by explicit newlines and wraps
  logic [8:0]  nl_y;
  logic [16:0] rec_full;
  logic [9:0]  total;
  logic        wrap;
  logic [8:0]  adv_x;

  assign nl_y = (10'(cursor_y) + 10'(vert) + 10'(vert) >= ph) ? start_y
                                                             : 9'(cursor_y + 9'(vert));
  assign rec_full = 17'(code_ofs) * 17'(font_bpc) + 17'(HDR_BYTES);
  assign total    = 10'(hor) * 10'(vert);
  assign wrap     = (10'(cursor_x) + 10'(hor)) > pw;
  assign adv_x    = ((10'(own_w) + 10'(CELL_GAP)) < 10'(hor))
                    ? 9'(cursor_x + 9'(own_w) + 9'(CELL_GAP))
                    : 9'(cursor_x + 9'(hor));

  // Emit control
  logic       fill_last;
  logic       emit_go;
  logic       emit_done;
  logic [2:0] cnt;

  assign cnt = (rem >= REMW'(4)) ? 3'd4 : 3'(rem);

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (in_func == FUNC_PUT) && is_print) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP:  state_next = ST_FILL;
      ST_FILL: begin
        if (fill_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer outputs
  // ---------------------------------------------------------------------
  always_comb begin
    s_tready  = (state == ST_IDLE);
    ram_we    = 1'b0;
    ram_raddr = rec;
    fill_last = 1'b0;
    emit_go   = 1'b0;
    emit_done = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ram_we = accept && (in_func == FUNC_LOAD);
      end
      ST_FILL: begin
        // Width byte first, then each column's bitmap bytes
        ram_raddr = iss_width ? rec : (col_addr + AW'(iss_half));
        fill_last = iss_width ? (ncols == 5'd0)
                              : (({1'b0, iss_col} == ncols - 5'd1) &&
                                 (iss_half || !two_bytes));
      end
      ST_EMIT: begin
        emit_go   = (rem != '0) && (!m_tvalid || m_tready);
        emit_done = (rem == '0) || (emit_go && (rem <= REMW'(4)));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------
  // Cursor: config writes load it; newline, wrap and advance move it
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
    end else if (cfg_wr && (cfg_idx == REG_START_X)) begin
      cursor_x <= pwdata[8:0];
    end else if (cfg_wr && (cfg_idx == REG_START_Y)) begin
      cursor_y <= pwdata[8:0];
    end else if (state == ST_IDLE) begin
      if (accept && (in_func == FUNC_PUT) && (in_code == CHAR_NEWLINE)) begin
        cursor_x <= start_x;
        cursor_y <= nl_y;
      end
    end else if (state == ST_PREP) begin
      if (wrap) begin
        cursor_x <= start_x;
        cursor_y <= nl_y;
      end
    end else if (emit_done) begin
      cursor_x <= adv_x;
    end
  end

  // ---------------------------------------------------------------------
  // Read issue and glyph setup
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == ST_FILL);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      code_ofs <= 7'(in_code - CHAR_FIRST);
    end
    if (state == ST_PREP) begin
      rec       <= rec_full[AW-1:0];
      col_addr  <= rec_full[AW-1:0] + AW'(1);
      ncols     <= (total == 10'd0) ? 5'd0 : hor;
      two_bytes <= (vert > 5'd8);
      iss_width <= 1'b1;
      iss_col   <= '0;
      iss_half  <= 1'b0;
    end
    if (state == ST_FILL) begin
      rd_tag <= '{is_width: iss_width, col: iss_col, half: iss_half};
      if (iss_width) begin
        iss_width <= 1'b0;
      end else if (two_bytes && !iss_half) begin
        iss_half <= 1'b1;
      end else begin
        iss_half <= 1'b0;
        iss_col  <= iss_col + 4'd1;
        col_addr <= col_addr + AW'(bytes_col);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Pixel buffer: scatter column bytes into row-major order, drain by four
  // ---------------------------------------------------------------------
  logic [9:0] pos [8];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pos[k] = (rd_tag.half ? {2'b0, hor, 3'b0} : 10'd0) +
               10'(k) * 10'(hor) + 10'(rd_tag.col);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      if (rd_tag.is_width) begin
        own_w <= ram_rdata;
      end else begin
        for (int k = 0; k < 8; k++) begin
          // Drop rows below the cell
          if ((5'({rd_tag.half, 3'(k)}) < vert) && (pos[k] < 10'(PIXB))) begin
            pix[pos[k][PIXW-1:0]] <= ram_rdata[k];
          end
        end
      end
    end else if (state == ST_PREP) begin
      rem <= REMW'(total);
    end else if (emit_go) begin
      pix <= pix >> 4;
      rem <= rem - REMW'(cnt);
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [15:0] fg;
  logic [15:0] bg;
  logic [15:0] px [4];
  logic [15:0] out_px [4];
  logic [2:0]  out_cnt;
  logic [8:0]  out_x0;
  logic [8:0]  out_y0;
  logic [8:0]  out_x1;
  logic [8:0]  out_y1;

  assign fg = colours[31:16];
  assign bg = colours[15:0];

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      px[q] = (3'(q) < cnt) ? swap16(pix[q] ? fg : bg) : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      for (int q = 0; q < 4; q++) begin
        out_px[q] <= px[q];
      end
      out_cnt <= cnt;
      out_x0  <= cursor_x;
      out_y0  <= cursor_y;
      out_x1  <= 9'(cursor_x + 9'(hor) - 9'd1);
      out_y1  <= 9'(cursor_y + 9'(vert) - 9'd1);
      m_tlast <= (rem <= REMW'(4));
    end
  end

  assign m_tdata = {1'b0, out_y1, out_x1, out_y0, out_x0, out_cnt,
                    out_px[3], out_px[2], out_px[1], out_px[0]};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `TGR_ASSERT_NEXT(a_rem_step, emit_go, rem == $past(rem) - REMW'($past(cnt)), "pixel count slip")
  `TGR_ASSERT_SAME(a_full_word, m_tvalid && !m_tlast, out_cnt == 3'd4, "short word before last")
  `TGR_ASSERT_SAME(a_rd_window, rd_valid, (state == ST_FILL) || (state == ST_DRAIN), "stray read")

endmodule

`default_nettype wire

// ===== test/tb_text_glyph_renderer_core.sv =====
`timescale 1ns / 100ps
// Testbench for text_glyph_renderer_core: loads font bytes, puts characters and
// checks every pixel word against its own prediction of the glyph renderer.
// Depends on tgr_pkg and the core RTL only.

module tb_text_glyph_renderer_core;
  import tgr_pkg::*;

  localparam int PANEL_W       = 240;
  localparam int PANEL_H       = 320;
  localparam int FONT_SIZE     = 4096;
  localparam int SIDE_MAX      = 16;
  // Allow margin for a glyph and for words still in flight.
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int MAX_REPORTS   = 10;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One output word as the checker sees it.
  typedef struct packed {
    logic [15:0] pix_a;
    logic [15:0] pix_b;
    logic [15:0] pix_c;
    logic [15:0] pix_d;
    logic [2:0]  count;
    logic [8:0]  x0;
    logic [8:0]  y0;
    logic [8:0]  x1;
    logic [8:0]  y1;
    logic        last;
  } pixel_word_t;

  // Every block input starts at a known value.
  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // [11:0] font_addr, [19:12] font_byte, [27:20] char_code, [31:28] zero
  logic [31:0]  s_tdata = '0;
  // [0] func
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // [15:0] pixel_a, [31:16] pixel_b, [47:32] pixel_c, [63:48] pixel_d,
  // [66:64] pixel_count, [75:67] win_x0, [84:76] win_y0, [93:85] win_x1,
  // [102:94] win_y1, [103] zero
  logic [103:0] m_tdata;
  logic         m_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Glyph renderer state as predicted: font memory, cursor and registers.
  logic [7:0]   font_mem [FONT_SIZE];
  bit           font_written [FONT_SIZE];
  logic [8:0]   cur_x = '0;
  logic [8:0]   cur_y = '0;
  logic [5:0]   reg_glyph_bytes = 6'd33;
  logic [4:0]   reg_cell_w = 5'd16;
  logic [4:0]   reg_cell_h = 5'd16;
  logic [1:0]   reg_col_bytes = 2'd2;
  logic [31:0]  reg_colours = '0;
  logic [8:0]   reg_start_x = '0;
  logic [8:0]   reg_start_y = '0;
  logic         reg_swap = 1'b0;

  pixel_word_t  word_q [$];
  int           err_count = 0;
  int           words_seen = 0;
  int           cycle_count = 0;
  int           src_idle_pct = 0;
  int           snk_stall_pct = 0;

  text_glyph_renderer_core #(
    .PANEL_WIDTH   (PANEL_W),
    .PANEL_HEIGHT  (PANEL_H),
    .FONT_BYTES    (FONT_SIZE),
    .MAX_GLYPH_SIDE(SIDE_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stall at random while the current mode asks for it.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Cell sides above the maximum saturate; zero stays zero (empty glyph).
  function automatic int unsigned clamp_side(input logic [4:0] v);
    return (v > SIDE_MAX) ? SIDE_MAX : 32'(v);
  endfunction

  // Start of the record of a printable code, wrapped into the font memory.
  function automatic int unsigned glyph_record(input logic [7:0] code);
    return ((32'(code) - CHAR_FIRST) * reg_glyph_bytes + HDR_BYTES) % FONT_SIZE;
  endfunction

  // Carriage return plus line feed; wrap back to the start row near the bottom.
  function automatic void next_line();
    int unsigned vert;
    int unsigned ph;
    vert = clamp_side(reg_cell_h);
    ph   = reg_swap ? PANEL_W : PANEL_H;
    cur_x = reg_start_x;
    if (cur_y + 2 * vert >= ph) cur_y = reg_start_y;
    else cur_y = 9'(cur_y + vert);
  endfunction

  // Queue the pixel words of one glyph, then advance the cursor.
  function automatic void predict_glyph(input logic [7:0] code);
    int unsigned pw;
    int unsigned hor;
    int unsigned vert;
    int unsigned rec;
    int unsigned own_w;
    int unsigned total;
    int unsigned n;
    int unsigned cnt;
    int unsigned i;
    int unsigned j;
    logic [7:0]  bits;
    logic [15:0] colour;
    logic [15:0] pix [4];
    pixel_word_t w;
    pw   = reg_swap ? PANEL_H : PANEL_W;
    hor  = clamp_side(reg_cell_w);
    vert = clamp_side(reg_cell_h);
    // Wrap first if the cell would cross the right panel edge.
    if (cur_x + hor > pw) next_line();
    rec   = glyph_record(code);
    own_w = font_mem[rec];
    total = hor * vert;
    n = 0;
    for (j = 0; j < vert; j++) begin
      for (i = 0; i < hor; i++) begin
        // Column-major bitmap, eight rows per byte, after the width byte.
        bits   = font_mem[(rec + reg_col_bytes * i + (j >> 3) + 1) % FONT_SIZE];
        colour = bits[j % 8] ? reg_colours[31:16] : reg_colours[15:0];
        pix[n % 4] = {colour[7:0], colour[15:8]};
        n++;
        if (n % 4 == 0 || n == total) begin
          cnt     = (n - 1) % 4 + 1;
          w.pix_a = pix[0];
          w.pix_b = (cnt > 1) ? pix[1] : 16'h0;
          w.pix_c = (cnt > 2) ? pix[2] : 16'h0;
          w.pix_d = (cnt > 3) ? pix[3] : 16'h0;
          w.count = 3'(cnt);
          w.x0    = cur_x;
          w.y0    = cur_y;
          w.x1    = 9'(cur_x + hor - 1);
          w.y1    = 9'(cur_y + vert - 1);
          w.last  = (n == total);
          word_q.push_back(w);
        end
      end
    end
    // Proportional advance, never wider than the cell.
    if (own_w + CELL_GAP < hor) cur_x = 9'(cur_x + own_w + CELL_GAP);
    else cur_x = 9'(cur_x + hor);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic string word_text(input pixel_word_t w);
    return $sformatf("px %h %h %h %h n=%0d win (%0d,%0d)-(%0d,%0d) last=%0b",
                     w.pix_a, w.pix_b, w.pix_c, w.pix_d, w.count,
                     w.x0, w.y0, w.x1, w.y1, w.last);
  endfunction

  // Compare each accepted output word with the oldest expected one.
  always @(posedge clk) begin
    pixel_word_t got;
    pixel_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.pix_a = m_tdata[15:0];
      got.pix_b = m_tdata[31:16];
      got.pix_c = m_tdata[47:32];
      got.pix_d = m_tdata[63:48];
      got.count = m_tdata[66:64];
      got.x0    = m_tdata[75:67];
      got.y0    = m_tdata[84:76];
      got.x1    = m_tdata[93:85];
      got.y1    = m_tdata[102:94];
      got.last  = m_tlast;
      words_seen++;
      if (word_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("ERROR word %0d arrived with none expected: %s", words_seen,
                   word_text(got));
      end else begin
        want = word_q.pop_front();
        if (got.pix_a !== want.pix_a || got.pix_b !== want.pix_b ||
            got.pix_c !== want.pix_c || got.pix_d !== want.pix_d ||
            got.count !== want.count || got.x0 !== want.x0 ||
            got.y0 !== want.y0 || got.x1 !== want.x1 ||
            got.y1 !== want.y1 || got.last !== want.last) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("ERROR word %0d expected %s", words_seen, word_text(want));
            $display("ERROR word %0d actual   %s", words_seen, word_text(got));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic void set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      IDLE_SENDER:   begin src_idle_pct = 87; snk_stall_pct = 0;  end
      IDLE_RECEIVER: begin src_idle_pct = 0;  snk_stall_pct = 87; end
      IDLE_BOTH:     begin src_idle_pct = 33; snk_stall_pct = 33; end
      default:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
    endcase
  endfunction

  // Send one input word. Call at a rising edge; returns at the accepting edge
  // with tvalid still high so back-to-back words need no extra assignment.
  task automatic send_word(input logic func, input logic [11:0] addr,
                           input logic [7:0] fbyte, input logic [7:0] code);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    if (func == FUNC_LOAD) begin
      font_mem[addr]     = fbyte;
      font_written[addr] = 1'b1;
    end else if (code == CHAR_NEWLINE) begin
      next_line();
    end else if (code >= CHAR_FIRST && code <= CHAR_LAST) begin
      predict_glyph(code);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0, code, fbyte, addr};
    do @(posedge clk); while (!s_tready);
  endtask

  // Unused fields carry random bits so the block must ignore them.
  task automatic load_font(input logic [11:0] addr, input logic [7:0] fbyte);
    send_word(FUNC_LOAD, addr, fbyte, 8'($urandom));
  endtask

  // Load every byte the glyph will read that was never written, so no read
  // of uninitialized font memory is ever caused.
  task automatic prime_glyph(input logic [7:0] code);
    int unsigned rec;
    int unsigned a;
    int unsigned i;
    int unsigned j;
    rec = glyph_record(code);
    // Width byte: mostly narrow so the proportional advance is exercised.
    if (!font_written[rec])
      load_font(12'(rec), ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                       : 8'($urandom_range(0, SIDE_MAX + 2)));
    for (j = 0; j < clamp_side(reg_cell_h); j++) begin
      for (i = 0; i < clamp_side(reg_cell_w); i++) begin
        a = (rec + reg_col_bytes * i + (j >> 3) + 1) % FONT_SIZE;
        if (!font_written[a]) load_font(12'(a), 8'($urandom));
      end
    end
  endtask

  task automatic put_char(input logic [7:0] code);
    if (code >= CHAR_FIRST && code <= CHAR_LAST) prime_glyph(code);
    send_word(FUNC_PUT, 12'($urandom), 8'($urandom), code);
  endtask

  // Drop tvalid and wait for every expected word, then let a glyph that
  // produced no words finish inside the block.
  task automatic wait_idle(input int extra);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (word_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready. Return to idle
  // after so back-to-back writes never reassign psel in one step.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FONT_BPC:  reg_glyph_bytes = value[5:0];
      REG_GLYPH_W:   reg_cell_w = value[4:0];
      REG_GLYPH_H:   reg_cell_h = value[4:0];
      REG_BYTES_COL: reg_col_bytes = value[1:0];
      REG_COLOURS:   reg_colours = value;
      REG_START_X:   begin reg_start_x = value[8:0]; cur_x = value[8:0]; end
      REG_START_Y:   begin reg_start_y = value[8:0]; cur_y = value[8:0]; end
      REG_SWAP_AXES: reg_swap = value[0];
      default:       ;
    endcase
  endtask

  // Drain, then write all registers; the start writes reload the cursor.
  task automatic set_config(input logic [5:0] rec_bytes, input logic [4:0] w,
                            input logic [4:0] h, input logic [1:0] col_bytes,
                            input logic [31:0] colours, input logic [8:0] sx,
                            input logic [8:0] sy, input logic swp);
    wait_idle(SETTLE_CYCLES);
    reg_write(REG_FONT_BPC, 32'(rec_bytes));
    reg_write(REG_GLYPH_W, 32'(w));
    reg_write(REG_GLYPH_H, 32'(h));
    reg_write(REG_BYTES_COL, 32'(col_bytes));
    reg_write(REG_COLOURS, colours);
    reg_write(REG_START_X, 32'(sx));
    reg_write(REG_START_Y, 32'(sy));
    reg_write(REG_SWAP_AXES, 32'(swp));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Font loads at both ends of the memory and with alternating bit patterns.
  task automatic test_font_loads();
    load_font(12'h000, 8'h00);
    load_font(12'hFFF, 8'hFF);
    load_font(12'hAAA, 8'h55);
    load_font(12'h555, 8'hAA);
  endtask

  // Full 16 x 16 cells at the reset layout: first and last printable codes,
  // a newline between two glyphs.
  task automatic test_full_cells();
    set_config(6'd33, 5'd16, 5'd16, 2'd2, 32'hF800_07E0, 9'd0, 9'd0, 1'b0);
    put_char(CHAR_FIRST);
    put_char(CHAR_LAST);
    put_char(8'h41);
    put_char(CHAR_NEWLINE);
    put_char(8'h41);
  endtask

  // Control codes, code 31 and the upper half must all be dropped.
  task automatic test_unprintable();
    put_char(8'd0);
    put_char(8'd9);
    put_char(8'd11);
    put_char(8'd31);
    put_char(8'd128);
    put_char(8'd255);
  endtask

  // Single pixel, partial last word, empty cells and saturated cells.
  task automatic test_cell_sizes();
    // Largest record size: the record of the last code wraps the memory.
    set_config(6'd63, 5'd1, 5'd1, 2'd1, 32'h0000_FFFF, 9'd0, 9'd0, 1'b0);
    put_char(CHAR_LAST);
    // Nine pixels: two full words and one with a single pixel.
    set_config(6'd33, 5'd3, 5'd3, 2'd1, 32'h1234_ABCD, 9'd0, 9'd0, 1'b0);
    put_char(8'h43);
    put_char(8'h43);
    // Zero height: no words, but the cursor still advances; a later glyph
    // shows where it went. Only the width and height registers are rewritten.
    wait_idle(SETTLE_CYCLES);
    reg_write(REG_GLYPH_W, 32'd5);
    reg_write(REG_GLYPH_H, 32'd0);
    put_char(8'h44);
    put_char(8'h44);
    wait_idle(SETTLE_CYCLES);
    reg_write(REG_GLYPH_H, 32'd4);
    put_char(8'h44);
    // Zero width: empty too.
    wait_idle(SETTLE_CYCLES);
    reg_write(REG_GLYPH_W, 32'd0);
    put_char(8'h44);
    wait_idle(SETTLE_CYCLES);
    reg_write(REG_GLYPH_W, 32'd2);
    put_char(8'h44);
    // Oversized cell saturates to the maximum side.
    set_config(6'd33, 5'd31, 5'd20, 2'd2, 32'hFFFF_FFFF, 9'd0, 9'd0, 1'b0);
    put_char(8'h45);
    // Tall cell with one byte per column: rows 8 and up read the next byte.
    set_config(6'd33, 5'd16, 5'd16, 2'd1, 32'h07E0_F81F, 9'd0, 9'd0, 1'b0);
    put_char(8'h46);
  endtask

  // Cursor edges: start beyond the rotated panel so columns wrap to 9 bits,
  // line wrap at the right edge, and the row wrap back to the start row.
  task automatic test_cursor_edges();
    set_config(6'd33, 5'd8, 5'd8, 2'd2, 32'h0000_0000, 9'd505, 9'd500, 1'b1);
    put_char(8'h47);
    put_char(8'h47);
    put_char(CHAR_NEWLINE);
    put_char(8'h48);
    set_config(6'd33, 5'd8, 5'd8, 2'd2, 32'hA5A5_5A5A, 9'd230, 9'd319, 1'b0);
    put_char(8'h4B);
    put_char(8'h4B);
    put_char(8'h4B);
    put_char(CHAR_NEWLINE);
    put_char(8'h4B);
  endtask

  // Random traffic under one idle mode: mostly glyphs from a small character
  // set so the font stays compact, with newlines, loads and dropped codes.
  task automatic test_random_traffic(input idle_mode_t mode, input logic [5:0] rec_bytes,
                                     input logic [1:0] col_bytes, input int n_items);
    logic [7:0] charset [6];
    logic [4:0] w;
    logic [4:0] h;
    logic [7:0] code;
    int         sent;
    int         r;
    bit         held;
    // Mostly small cells to keep the run short; some full ones.
    w = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(9, 16)) : 5'($urandom_range(1, 8));
    h = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(9, 16)) : 5'($urandom_range(1, 8));
    set_config(rec_bytes, w, h, col_bytes, $urandom, 9'($urandom_range(0, 60)),
               9'($urandom_range(0, 120)), 1'($urandom_range(0, 1)));
    set_idle(mode);
    foreach (charset[k]) charset[k] = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
    sent = 0;
    held = 1'b0;
    while (sent < n_items) begin
      // Pause the sender once until every expected word has come.
      if (!held && sent == n_items / 2) begin
        wait_idle(0);
        held = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        put_char(charset[$urandom_range(0, 5)]);
      end else if (r < 70) begin
        put_char(8'($urandom_range(CHAR_FIRST, CHAR_LAST)));
      end else if (r < 80) begin
        put_char(CHAR_NEWLINE);
      end else if (r < 95) begin
        load_font(12'($urandom), 8'($urandom));
      end else begin
        // Dropped code: does not count toward the item total.
        code = $urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                    : 8'($urandom_range(0, 31));
        if (code == CHAR_NEWLINE) code = 8'd31;
        put_char(code);
        continue;
      end
      sent++;
    end
  endtask

  initial begin
    // Hold reset once, at the start of the run.
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_idle(IDLE_NONE);
    test_font_loads();
    test_full_cells();
    test_unprintable();
    test_cell_sizes();
    test_cursor_edges();
    test_random_traffic(IDLE_NONE, 6'd63, 2'd2, 45);
    test_random_traffic(IDLE_SENDER, 6'd1, 2'd1, 45);
    test_random_traffic(IDLE_RECEIVER, 6'($urandom_range(1, 63)), 2'd2, 45);
    test_random_traffic(IDLE_BOTH, 6'($urandom_range(1, 63)), 2'd1, 45);
    wait_idle(SETTLE_CYCLES);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== text_glyph_renderer_core.f =====
+incdir+rtl
rtl/tgr_pkg.sv
rtl/tgr_ram.sv
rtl/text_glyph_renderer_core.sv
test/tb_text_glyph_renderer_core.sv
